@@ hdl/pea_pkg.sv @@
// shared constants for the page extent allocator
// status codes and default sizes; no dependencies
`default_nettype none
package pea_pkg;

  localparam int MAX_RUNS_DEF       = 16;
  localparam int PAGE_ADDR_BITS_DEF = 20;
  localparam int STATUS_W           = 3;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOMEM   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERLAP = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

endpackage
`default_nettype wire

@@ hdl/pea_ram.sv @@
// generic simple dual port ram, one write port and one registered read port
// no dependencies
`default_nettype none
module pea_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule
`default_nettype wire

@@ hdl/page_extent_allocator.sv @@
// Page extent allocator top level: first-fit free-run table with coalescing.
// Depends on pea_pkg and pea_ram.
//
// The block keeps an address-sorted table of free runs in one ram and serves
// one request at a time. An allocate reads entries one by one until the first
// run long enough; a free reads every entry to check overlap and find its
// neighbours. A removal or insertion then moves the following entries one
// place, by a ram read and a ram write per entry moved. The time a request
// takes is set by the entry-by-entry ram walk; zero-count requests skip it.
// in_tready is low while a request is in progress. The table starts empty and
// needs no clearing after reset.
`default_nettype none
module page_extent_allocator
  import pea_pkg::*;
#(
  parameter int MAX_RUNS       = MAX_RUNS_DEF,
  parameter int PAGE_ADDR_BITS = PAGE_ADDR_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // base_page, page_count
  input  wire logic [((2*PAGE_ADDR_BITS+1+7)/8)*8-1:0] in_tdata,
  // kind
  input  wire logic in_tuser,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // status, alloc_page
  output logic [((STATUS_W+PAGE_ADDR_BITS+7)/8)*8-1:0] out_tdata
);

  localparam int PW = PAGE_ADDR_BITS;
  localparam int LW = PAGE_ADDR_BITS + 1;
  localparam int CW = $clog2(MAX_RUNS + 1);
  localparam int IW = $clog2(MAX_RUNS);
  localparam int OW = ((STATUS_W + PAGE_ADDR_BITS + 7) / 8) * 8;
  localparam int EW = PW + LW;

  typedef enum logic [3:0] {
    S_IDLE, S_A_RD, S_A_CHK, S_F_RD, S_F_CHK, S_F_DEC,
    S_SH_CHK, S_SH_RD, S_SH_WR, S_DONE
  } state_t;

  state_t              state_r;
  logic                kind_r;
  logic [PW-1:0]       base_r;
  logic [LW-1:0]       cnt_r;
  logic [CW-1:0]       total_r;
  logic [CW-1:0]       idx_r;
  logic [CW-1:0]       pos_r;
  logic [CW-1:0]       shk_r;
  logic                sh_up_r;
  logic                ovl_r;
  logic [PW-1:0]       prev_base_r;
  logic [LW-1:0]       prev_len_r;
  logic [PW-1:0]       next_base_r;
  logic [LW-1:0]       next_len_r;
  logic [STATUS_W-1:0] res_status_r;
  logic [PW-1:0]       res_page_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [PW-1:0]       out_page_r;
  logic                out_valid_r;

  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [EW-1:0]       wr_data;
  logic [IW-1:0]       rd_addr;
  logic [EW-1:0]       rd_data;

  logic [PW-1:0]       in_base;
  logic [LW-1:0]       in_cnt;
  logic [LW-1:0]       lim;
  logic [PW-1:0]       rb;
  logic [LW-1:0]       rl;
  logic [LW-1:0]       rend;
  logic [LW-1:0]       fend;
  logic [LW-1:0]       prev_end;
  logic [LW-1:0]       rem_len;
  logic                mprev;
  logic                mnext;
  logic                last_entry;

  assign in_base    = in_tdata[PW-1:0];
  assign in_cnt     = in_tdata[PW+LW-1:PW];
  assign lim        = {1'b1, {PW{1'b0}}} - {1'b0, in_base};
  assign rb         = rd_data[PW-1:0];
  assign rl         = rd_data[EW-1:PW];
  assign rend       = {1'b0, rb} + rl;
  assign fend       = {1'b0, base_r} + cnt_r;
  assign prev_end   = {1'b0, prev_base_r} + prev_len_r;
  assign rem_len    = rl - cnt_r;
  assign mprev      = (pos_r != '0) && (prev_end == {1'b0, base_r});
  assign mnext      = (pos_r < total_r) && ({1'b0, next_base_r} == fend);
  assign last_entry = (idx_r + CW'(1)) >= total_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OW'({out_page_r, out_status_r});

  pea_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_RUNS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // ram port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    rd_addr = idx_r[IW-1:0];
    unique case (state_r)
      S_A_CHK: begin
        wr_en   = (rl > cnt_r);
        wr_addr = idx_r[IW-1:0];
        wr_data = {rem_len, rb};
      end
      S_F_DEC: begin
        if (!ovl_r) begin
          if (mprev) begin
            wr_en   = 1'b1;
            wr_addr = IW'(pos_r - CW'(1));
            wr_data = {prev_len_r + cnt_r + (mnext ? next_len_r : '0), prev_base_r};
          end else if (mnext) begin
            wr_en   = 1'b1;
            wr_addr = pos_r[IW-1:0];
            wr_data = {next_len_r + cnt_r, base_r};
          end
        end
      end
      S_SH_CHK: begin
        wr_en   = sh_up_r && (shk_r == pos_r);
        wr_addr = pos_r[IW-1:0];
        wr_data = {cnt_r, base_r};
      end
      S_SH_RD: begin
        rd_addr = sh_up_r ? IW'(shk_r - CW'(1)) : IW'(shk_r + CW'(1));
      end
      S_SH_WR: begin
        wr_en   = 1'b1;
        wr_addr = shk_r[IW-1:0];
        wr_data = rd_data;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            kind_r       <= in_tuser;
            base_r       <= in_base;
            cnt_r        <= (in_tuser && in_cnt > lim) ? lim : in_cnt;
            idx_r        <= '0;
            pos_r        <= '0;
            ovl_r        <= 1'b0;
            res_status_r <= ST_OK;
            res_page_r   <= '0;
            if (in_cnt == '0) begin
              res_status_r <= ST_ZERO;
              state_r      <= S_DONE;
            end else if (!in_tuser) begin
              if (total_r == '0) begin
                res_status_r <= ST_NOMEM;
                state_r      <= S_DONE;
              end else begin
                state_r <= S_A_RD;
              end
            end else begin
              state_r <= (total_r == '0) ? S_F_DEC : S_F_RD;
            end
          end
        end
        S_A_RD: begin
          state_r <= S_A_CHK;
        end
        S_A_CHK: begin
          if (rl == cnt_r) begin
            res_page_r <= rb;
            shk_r      <= idx_r;
            sh_up_r    <= 1'b0;
            state_r    <= S_SH_CHK;
          end else if (rl > cnt_r) begin
            res_page_r <= PW'({1'b0, rb} + rem_len);
            state_r    <= S_DONE;
          end else if (last_entry) begin
            res_status_r <= ST_NOMEM;
            state_r      <= S_DONE;
          end else begin
            idx_r   <= idx_r + CW'(1);
            state_r <= S_A_RD;
          end
        end
        S_F_RD: begin
          state_r <= S_F_CHK;
        end
        S_F_CHK: begin
          if ({1'b0, base_r} < rend && {1'b0, rb} < fend) begin
            ovl_r <= 1'b1;
          end
          if (rb < base_r) begin
            prev_base_r <= rb;
            prev_len_r  <= rl;
            pos_r       <= idx_r + CW'(1);
          end else if (idx_r == pos_r) begin
            next_base_r <= rb;
            next_len_r  <= rl;
          end
          idx_r   <= idx_r + CW'(1);
          state_r <= last_entry ? S_F_DEC : S_F_RD;
        end
        S_F_DEC: begin
          if (ovl_r) begin
            res_status_r <= ST_OVERLAP;
            state_r      <= S_DONE;
          end else if (mprev && mnext) begin
            shk_r   <= pos_r;
            sh_up_r <= 1'b0;
            state_r <= S_SH_CHK;
          end else if (mprev || mnext) begin
            state_r <= S_DONE;
          end else if (total_r >= CW'(MAX_RUNS)) begin
            res_status_r <= ST_FULL;
            state_r      <= S_DONE;
          end else begin
            shk_r   <= total_r;
            sh_up_r <= 1'b1;
            state_r <= S_SH_CHK;
          end
        end
        S_SH_CHK: begin
          if (sh_up_r) begin
            if (shk_r == pos_r) begin
              total_r <= total_r + CW'(1);
              state_r <= S_DONE;
            end else begin
              state_r <= S_SH_RD;
            end
          end else if ((shk_r + CW'(1)) >= total_r) begin
            total_r <= total_r - CW'(1);
            state_r <= S_DONE;
          end else begin
            state_r <= S_SH_RD;
          end
        end
        S_SH_RD: begin
          state_r <= S_SH_WR;
        end
        S_SH_WR: begin
          shk_r   <= sh_up_r ? shk_r - CW'(1) : shk_r + CW'(1);
          state_r <= S_SH_CHK;
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_page_r   <= (res_status_r == ST_OK && !kind_r) ? res_page_r : '0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/pea_checker.sv @@
// port-level checks for the page extent allocator, bound to the top level
// depends on pea_pkg
`default_nettype none
module pea_checker
  import pea_pkg::*;
#(
  parameter int PAGE_ADDR_BITS = PAGE_ADDR_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_tvalid,
  input wire logic in_tready,
  input wire logic out_tvalid,
  input wire logic out_tready,
  input wire logic [((STATUS_W+PAGE_ADDR_BITS+7)/8)*8-1:0] out_tdata
);

  logic [STATUS_W-1:0]       st;
  logic [PAGE_ADDR_BITS-1:0] pg;

  assign st = out_tdata[STATUS_W-1:0];
  assign pg = out_tdata[STATUS_W+PAGE_ADDR_BITS-1:STATUS_W];

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (st == ST_OK || st == ST_NOMEM || st == ST_OVERLAP ||
                    st == ST_ZERO || st == ST_FULL))
    else $error("status code out of range");

  a_page: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st != ST_OK |-> pg == '0)
    else $error("page given on failed request");

  // one request in progress at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("word taken while busy");

endmodule

bind page_extent_allocator pea_checker #(
  .PAGE_ADDR_BITS(PAGE_ADDR_BITS)
) u_pea_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
`default_nettype wire
